FILE: rtl/core/gda_pkg.sv
// Package: constants, sequencer states, unit operations and calendar functions for the date adder.
package gda_pkg;

  localparam int YEAR_BITS_DEF  = 14;
  localparam int COUNT_BITS_DEF = 16;

  localparam int R400_W = 9;
  localparam int LEN_W  = 9;
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;

  // split 400 as 25 * 16; the reciprocal of 25 is exact for dividends below 91180
  localparam int CYCLE_LOW_W = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 21;
  localparam logic [DAY_W-1:0]   CYCLE_DIV = DAY_W'(25);
  localparam logic [RECIP_W-1:0] RECIP_DIV = RECIP_W'(83887);

  localparam logic [R400_W-1:0] CENTURY_1     = R400_W'(100);
  localparam logic [R400_W-1:0] CENTURY_2     = R400_W'(200);
  localparam logic [R400_W-1:0] CENTURY_3     = R400_W'(300);
  localparam logic [R400_W-1:0] CYCLE_LAST    = R400_W'(399);
  localparam logic [LEN_W-1:0]  YEAR_DAYS     = LEN_W'(365);
  localparam logic [LEN_W-1:0]  LEAP_YEAR_DAYS = LEN_W'(366);
  localparam logic [DAY_W-1:0]  FEB_DAYS      = DAY_W'(28);
  localparam logic [DAY_W-1:0]  FEB_LEAP_DAYS = DAY_W'(29);

  localparam logic [MON_W-1:0] MONTH_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHK,
    ST_DOY,
    ST_REM,
    ST_CMP,
    ST_ADDX,
    ST_YEAR,
    ST_MON,
    ST_DONE
  } gda_state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } gda_op_t;

  function automatic logic is_leap(input logic [R400_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2) && (r != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                  n = DAY_W'(30);
      MONTH_FEB:                                n = leap ? FEB_LEAP_DAYS : FEB_DAYS;
      default:                                  n = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/gda_in_if.sv
// Interface: input channel carrying the start date and day count.
interface gda_in_if #(
  parameter int YEAR_BITS  = gda_pkg::YEAR_BITS_DEF,
  parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [4:0]            day;
  logic [3:0]            month;
  logic [YEAR_BITS-1:0]  year;
  logic [COUNT_BITS-1:0] days_to_add;

  modport source (output valid, day, month, year, days_to_add, input ready);
  modport sink   (input valid, day, month, year, days_to_add, output ready);
endinterface

FILE: rtl/core/gda_out_if.sv
// Interface: output channel carrying the resulting date and error flags.
interface gda_out_if #(
  parameter int YEAR_BITS = gda_pkg::YEAR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           new_day;
  logic [3:0]           new_month;
  logic [YEAR_BITS-1:0] new_year;
  logic                 bad_date;
  logic                 year_overflow;

  modport source (output valid, new_day, new_month, new_year, bad_date, year_overflow,
                  input ready);
  modport sink   (input valid, new_day, new_month, new_year, bad_date, year_overflow,
                  output ready);
endinterface

FILE: rtl/core/gda_alu.sv
// Shared add/subtract unit; carry out doubles as borrow on subtract.
module gda_alu #(
  parameter int W = 16
) (
  input  gda_pkg::gda_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             co
);
  import gda_pkg::*;

  always_comb begin
    if (op == OP_ADD) begin
      {co, res} = {1'b0, a} + {1'b0, b};
    end else begin
      {co, res} = {1'b0, a} - {1'b0, b};
    end
  end
endmodule

FILE: rtl/core/gregorian_date_add_days.sv
// Top level: sequencer, datapath registers and output register of the date adder.
//
//  channel   | dir | handshake   | payload
//  in_item   | in  | valid/ready | day, month, year, days_to_add
//  out_item  | out | valid/ready | new_day, new_month, new_year, bad_date, year_overflow
//
// An item is accepted, its year is reduced mod 400 by a reciprocal multiply, month and day
// are checked, the day of year is summed month by month, the days left in the year are
// compared with the count, the year loop steps year by year, the month loop walks the months
// and the result is loaded; the year loop on the shared add/sub unit sets the run time.
// rst is synchronous and clears the sequencer and output valid.
// in_item.ready is high only while idle; a finished result waits in the output register
// and the next item is taken while it waits.
module gregorian_date_add_days #(
  parameter int YEAR_BITS  = gda_pkg::YEAR_BITS_DEF,
  parameter int COUNT_BITS = gda_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gda_in_if.sink    in_item,
  gda_out_if.source out_item
);
  import gda_pkg::*;

  localparam int UW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
  localparam int YW = YEAR_BITS + 1;
  localparam int ZW = YEAR_BITS - CYCLE_LOW_W;
  localparam int PW = ZW + RECIP_W;
  localparam int QW = PW - RECIP_SHIFT;

  gda_state_t state, state_next;

  logic [DAY_W-1:0]  d_r, d_r_next;
  logic [MON_W-1:0]  m_r, m_r_next;
  logic [MON_W-1:0]  mo, mo_next;
  logic [YW-1:0]     y2, y2_next;
  logic [UW-1:0]     x, x_next;
  logic [UW-1:0]     acc, acc_next;
  logic [UW-1:0]     tmp, tmp_next;
  logic [R400_W-1:0] r400, r400_next;
  logic [QW-1:0]     quo, quo_next;
  logic              bad, bad_next;
  logic              ovf, ovf_next;

  logic              out_valid;
  logic [DAY_W-1:0]  out_day;
  logic [MON_W-1:0]  out_month;
  logic [YEAR_BITS-1:0] out_year;
  logic              out_bad;
  logic              out_ovf;
  logic              load_out;

  gda_op_t           op;
  logic [UW-1:0]     a, b, res;
  logic              co;
  logic              leap;
  logic [DAY_W-1:0]  dim_cur;
  logic [LEN_W-1:0]  ylen;
  logic [R400_W-1:0] r400_inc;
  logic [YEAR_BITS-1:0] ycur;
  logic [ZW-1:0]     yhi;
  logic [PW-1:0]     prod;
  logic [ZW-1:0]     r25;

  gda_alu #(.W(UW)) u_alu (
    .op  (op),
    .a   (a),
    .b   (b),
    .res (res),
    .co  (co)
  );

  assign ycur     = y2[YEAR_BITS-1:0];
  assign leap     = is_leap(r400);
  assign dim_cur  = month_days(mo, leap);
  assign ylen     = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
  assign r400_inc = (r400 == CYCLE_LAST) ? '0 : r400 + R400_W'(1);
  assign yhi      = ycur[YEAR_BITS-1:CYCLE_LOW_W];
  assign prod     = PW'(yhi) * PW'(RECIP_DIV);
  assign r25      = yhi - ZW'(quo) * ZW'(CYCLE_DIV);

  assign in_item.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    d_r  <= d_r_next;
    m_r  <= m_r_next;
    mo   <= mo_next;
    y2   <= y2_next;
    x    <= x_next;
    acc  <= acc_next;
    tmp  <= tmp_next;
    r400 <= r400_next;
    quo  <= quo_next;
    bad  <= bad_next;
    ovf  <= ovf_next;
  end

  always_comb begin
    state_next = state;
    d_r_next   = d_r;
    m_r_next   = m_r;
    mo_next    = mo;
    y2_next    = y2;
    x_next     = x;
    acc_next   = acc;
    tmp_next   = tmp;
    r400_next  = r400;
    quo_next   = quo;
    bad_next   = bad;
    ovf_next   = ovf;
    op         = OP_SUB;
    a          = '0;
    b          = '0;
    load_out   = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_item.valid) begin
          d_r_next   = in_item.day;
          m_r_next   = in_item.month;
          y2_next    = {1'b0, in_item.year};
          x_next     = UW'(in_item.days_to_add);
          r400_next  = '0;
          bad_next   = 1'b0;
          ovf_next   = 1'b0;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        quo_next   = prod[PW-1:RECIP_SHIFT];
        state_next = ST_CHK;
      end
      ST_CHK: begin
        mo_next   = m_r;
        r400_next = {r25[DAY_W-1:0], ycur[CYCLE_LOW_W-1:0]};
        if (m_r == '0 || m_r > MONTH_DEC || d_r == '0) begin
          bad_next   = 1'b1;
          state_next = ST_DONE;
        end else begin
          state_next = ST_DOY;
        end
      end
      ST_DOY: begin
        if (mo == m_r) begin
          a = UW'(dim_cur);
          b = UW'(d_r);
          if (co) begin
            bad_next   = 1'b1;
            state_next = ST_DONE;
          end else begin
            acc_next   = UW'(d_r);
            mo_next    = MONTH_JAN;
            state_next = ST_REM;
          end
        end else begin
          state_next = ST_DOY;
          mo_next    = MONTH_JAN;
        end
      end
      ST_REM: begin
        if (mo == m_r) begin
          a = UW'(ylen);
          b = acc;
          tmp_next   = res;
          state_next = ST_CMP;
        end else begin
          op       = OP_ADD;
          a        = acc;
          b        = UW'(dim_cur);
          acc_next = res;
          mo_next  = mo + MON_W'(1);
        end
      end
      ST_CMP: begin
        a = x;
        b = tmp;
        if (co || res == '0) begin
          state_next = ST_ADDX;
        end else begin
          x_next     = res;
          y2_next    = y2 + YW'(1);
          r400_next  = r400_inc;
          state_next = ST_YEAR;
        end
      end
      ST_ADDX: begin
        op         = OP_ADD;
        a          = acc;
        b          = x;
        acc_next   = res;
        mo_next    = MONTH_JAN;
        state_next = ST_MON;
      end
      ST_YEAR: begin
        if (y2[YW-1]) begin
          ovf_next   = 1'b1;
          state_next = ST_DONE;
        end else begin
          a = x;
          b = UW'(ylen);
          if (!co && res != '0) begin
            x_next    = res;
            y2_next   = y2 + YW'(1);
            r400_next = r400_inc;
          end else begin
            acc_next   = x;
            mo_next    = MONTH_JAN;
            state_next = ST_MON;
          end
        end
      end
      ST_MON: begin
        a = acc;
        b = UW'(dim_cur);
        if (mo != MONTH_DEC && !co && res != '0) begin
          acc_next = res;
          mo_next  = mo + MON_W'(1);
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_item.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_bad   <= bad;
      out_ovf   <= ovf;
      out_day   <= (bad || ovf) ? '0 : acc[DAY_W-1:0];
      out_month <= (bad || ovf) ? '0 : mo;
      out_year  <= (bad || ovf) ? '0 : ycur;
    end
  end

  assign out_item.valid         = out_valid;
  assign out_item.new_day       = out_day;
  assign out_item.new_month     = out_month;
  assign out_item.new_year      = out_year;
  assign out_item.bad_date      = out_bad;
  assign out_item.year_overflow = out_ovf;

endmodule

FILE: rtl/core/gda_checker.sv
// Checker: port-level assertions for the date adder, bound to the top level.
module gda_checker #(
  parameter int YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [4:0]           new_day,
  input logic [3:0]           new_month,
  input logic [YEAR_BITS-1:0] new_year,
  input logic                 bad_date,
  input logic                 year_overflow
);
  import gda_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (bad_date || year_overflow) |->
      new_day == '0 && new_month == '0 && new_year == '0)
    else $error("error result carries a nonzero date");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_date && year_overflow))
    else $error("both error flags raised");

  a_real_date: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_date && !year_overflow |->
      new_day != '0 && new_month != '0 && new_month <= MONTH_DEC)
    else $error("result date out of range");

endmodule

bind gregorian_date_add_days gda_checker #(.YEAR_BITS(YEAR_BITS)) u_gda_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .new_day       (out_item.new_day),
  .new_month     (out_item.new_month),
  .new_year      (out_item.new_year),
  .bad_date      (out_item.bad_date),
  .year_overflow (out_item.year_overflow)
);
